>>> hw/rtl/fisa_pkg.sv
// Shared types and constants for the free index stack allocator.
// No dependencies; used by the control and top modules of the block and by its checker.
package fisa_pkg;

	// Operation selected by the mode field
	typedef enum logic {
		MODE_ALLOC   = 1'b0,
		MODE_RELEASE = 1'b1
	} mode_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_EXHAUSTED    = 3'd1,
		ST_RANGE        = 3'd2,
		ST_NONE_OUT     = 3'd3,
		ST_INCONSISTENT = 3'd4
	} status_t;

	// Decision made for one request at accept time
	typedef struct packed {
		status_t status;
		logic    grant;    // allocate succeeded, a slot number goes out
		logic    use_mem;  // slot comes from the stack memory, not the identity order
	} dec_t;

	localparam int GRANT_W = 6;
	localparam int COUNT_W = 7;
	localparam int REL_W   = 8;

endpackage

>>> hw/rtl/fisa_stack_mem.sv
// Free-slot stack storage: one write port, one registered read port.
// Depends on nothing; instantiated by free_index_stack_allocator.
module fisa_stack_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int DW    = 6
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered; holds its data between reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

>>> hw/rtl/fisa_ctrl.sv
// Stack pointer and fill mark, request checks, and memory port control.
// Depends on fisa_pkg; instantiated by free_index_stack_allocator.
module fisa_ctrl #(
	parameter int POOL_SIZE = 64,
	parameter int AW        = 6,
	parameter int CW        = 7
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    acc,
	input  logic                    mode,
	input  logic [fisa_pkg::REL_W-1:0] release_slot,
	output fisa_pkg::dec_t          dec,
	output logic [CW-1:0]           top_nx,
	output logic [AW-1:0]           ident,
	output logic                    rd_en,
	output logic [AW-1:0]           rd_addr,
	output logic                    wr_en,
	output logic [AW-1:0]           wr_addr,
	output logic [AW-1:0]           wr_data
);
	import fisa_pkg::*;

	localparam int CMPW = (CW > REL_W) ? CW : REL_W;

	logic [CW-1:0] top_q;
	logic [CW-1:0] hwm_q;   // highest top reached; entries at or above it hold identity
	logic [CW-1:0] top_dec;
	logic          is_alloc;
	logic          full;
	logic          empty;
	logic          rel_bad;
	logic          ok;
	status_t       st;

	assign is_alloc = (mode == MODE_ALLOC);
	assign full     = (top_q == CW'(POOL_SIZE));
	assign empty    = (top_q == '0);
	assign rel_bad  = (CMPW'(release_slot) >= CMPW'(POOL_SIZE));
	assign top_dec  = top_q - CW'(1);

	// request checks; entries below the top are always taken, so the
	// stack never goes inconsistent
	always_comb begin
		if (is_alloc) begin
			st = full ? ST_EXHAUSTED : ST_OK;
		end else if (rel_bad) begin
			st = ST_RANGE;
		end else if (empty) begin
			st = ST_NONE_OUT;
		end else begin
			st = ST_OK;
		end
	end

	assign ok = (st == ST_OK);

	assign dec.status  = st;
	assign dec.grant   = is_alloc && ok;
	assign dec.use_mem = (top_q != hwm_q);

	// next top, also the in-use count reported for this request
	always_comb begin
		top_nx = top_q;
		if (ok) begin
			top_nx = is_alloc ? top_q + CW'(1) : top_dec;
		end
	end

	assign ident = top_q[AW-1:0];

	// memory ports: allocate reads the top entry, release writes below the top
	assign rd_en   = acc && ok && is_alloc;
	assign rd_addr = top_q[AW-1:0];
	assign wr_en   = acc && ok && !is_alloc;
	assign wr_addr = top_dec[AW-1:0];
	assign wr_data = AW'(release_slot);

	// pointer and fill mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= '0;
			hwm_q <= '0;
		end else if (acc) begin
			top_q <= top_nx;
			if (rd_en && (top_q == hwm_q)) begin
				hwm_q <= hwm_q + CW'(1);
			end
		end
	end

endmodule

>>> hw/rtl/free_index_stack_allocator.sv
// Free index stack allocator: hands out and takes back slot numbers of a fixed pool.
// A result goes through the memory read register, then the output register.
// Throughput: one request per cycle unless the output stalls; each request uses either
// the read port or the write port, never both; a write is seen by the next cycle's read.
// Reset: asynchronous; stack top and fill mark clear at once, no memory clearing pass
// (entries at or above the fill mark read as the identity order).
module free_index_stack_allocator #(
	parameter int POOL_SIZE = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          mode,
	input  logic [fisa_pkg::REL_W-1:0]    release_slot,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [fisa_pkg::GRANT_W-1:0]  granted_slot,
	output fisa_pkg::status_t             status,
	output logic [fisa_pkg::COUNT_W-1:0]  in_use_count
);
	import fisa_pkg::*;

	localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
	localparam int CW = $clog2(POOL_SIZE + 1);

	dec_t          dec;
	logic [CW-1:0] top_nx;
	logic [AW-1:0] ident;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] wr_data;
	logic [AW-1:0] rd_data;
	logic          acc;
	logic          s1_adv;
	logic [AW-1:0] slot_val;

	logic          valid_s1;
	dec_t          dec_s1;
	logic [CW-1:0] count_s1;
	logic [AW-1:0] ident_s1;

	logic                 out_valid_q;
	logic [GRANT_W-1:0]   grant_q;
	status_t              status_q;
	logic [COUNT_W-1:0]   count_q;

	// handshake
	assign s1_adv   = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || s1_adv;
	assign acc      = in_valid && in_ready;

	fisa_ctrl #(
		.POOL_SIZE(POOL_SIZE),
		.AW       (AW),
		.CW       (CW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.acc         (acc),
		.mode        (mode),
		.release_slot(release_slot),
		.dec         (dec),
		.top_nx      (top_nx),
		.ident       (ident),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data)
	);

	fisa_stack_mem #(
		.DEPTH(POOL_SIZE),
		.AW   (AW),
		.DW   (AW)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// stage 1: request decided, stack read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			dec_s1   <= dec;
			count_s1 <= top_nx;
			ident_s1 <= ident;
		end
	end

	// pick stored slot or identity value
	assign slot_val = dec_s1.use_mem ? rd_data : ident_s1;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && valid_s1) begin
			grant_q  <= dec_s1.grant ? GRANT_W'(slot_val) : '0;
			status_q <= dec_s1.status;
			count_q  <= COUNT_W'(count_s1);
		end
	end

	assign out_valid    = out_valid_q;
	assign granted_slot = grant_q;
	assign status       = status_q;
	assign in_use_count = count_q;

endmodule

>>> hw/rtl/fisa_checker.sv
// Port-level checks for the free index stack allocator, bound to the top level.
// Depends on fisa_pkg and free_index_stack_allocator.
module fisa_checker #(
	parameter int POOL_SIZE = 64
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          mode,
	input logic [fisa_pkg::REL_W-1:0]    release_slot,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [fisa_pkg::GRANT_W-1:0]  granted_slot,
	input fisa_pkg::status_t             status,
	input logic [fisa_pkg::COUNT_W-1:0]  in_use_count
);
	import fisa_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(granted_slot)
			&& $stable(status) && $stable(in_use_count))
		else $error("result changed while stalled");

	// the stack never reports itself inconsistent
	a_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != ST_INCONSISTENT)
		else $error("free list inconsistent");

	// a nonzero slot only goes out with an ok status
	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && granted_slot != '0 |-> status == ST_OK)
		else $error("slot granted on failed request");

	// nothing outstanding means an empty pool count
	a_none_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_NONE_OUT |-> in_use_count == '0)
		else $error("nothing outstanding with nonzero count");

	// exhausted means every slot is in use
	a_exhausted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EXHAUSTED |-> in_use_count == COUNT_W'(POOL_SIZE))
		else $error("exhausted with free slots left");

endmodule

bind free_index_stack_allocator fisa_checker #(.POOL_SIZE(POOL_SIZE)) u_fisa_checker (.*);

>>> verif/fisa_checker.sv
// Checker for the free index stack allocator: keeps its own copy of the free-slot
// stack, works out each result and compares it with what the block returns.
// Depends on fisa_pkg for the status codes, the mode encoding and the field widths.
module fisa_scoreboard #(
	parameter int POOL_SIZE = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic                         mode,
	input  logic [fisa_pkg::REL_W-1:0]   release_slot,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [fisa_pkg::GRANT_W-1:0] granted_slot,
	input  fisa_pkg::status_t            status,
	input  logic [fisa_pkg::COUNT_W-1:0] in_use_count,
	output int                           fail_count,
	output int                           pending,
	output int                           checked,
	output int                           peak_in_use,
	output int                           exhausted_hits,
	output int                           none_out_hits
);
	timeunit 1ns;
	timeprecision 1ps;
	import fisa_pkg::*;

	localparam int SLOT_W = $clog2(POOL_SIZE);

	// One result as the block reports it
	typedef struct packed {
		logic [GRANT_W-1:0] granted;
		status_t            status;
		logic [COUNT_W-1:0] count;
	} alloc_result_t;

	// Stack entry: a free slot number plus the taken mark
	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              taken;
	} stack_entry_t;

	stack_entry_t  free_list [POOL_SIZE];
	int unsigned   top_of_stack;
	alloc_result_t owed_results [$];

	initial begin
		fail_count     = 0;
		pending        = 0;
		checked        = 0;
		peak_in_use    = 0;
		exhausted_hits = 0;
		none_out_hits  = 0;
	end

	task automatic flag_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	// Apply one request to the stack copy and return the result it should give
	task automatic step_free_stack(input mode_t op, input logic [REL_W-1:0] slot,
			output alloc_result_t res);
		int unsigned       grant_wide;
		logic [SLOT_W-1:0] top_idx;
		logic [SLOT_W-1:0] below_idx;
		grant_wide = 0;
		top_idx    = SLOT_W'(top_of_stack);
		below_idx  = SLOT_W'(top_of_stack - 1);
		res.status = ST_OK;
		if (op == MODE_ALLOC) begin
			if (top_of_stack >= POOL_SIZE) begin
				res.status = ST_EXHAUSTED;
			end else if (free_list[top_idx].taken) begin
				res.status = ST_INCONSISTENT;
			end else begin
				grant_wide = 32'(free_list[top_idx].slot);
				free_list[top_idx].taken = 1'b1;
				top_of_stack++;
			end
		end else begin
			// range check wins over every other release check
			if (32'(slot) >= POOL_SIZE) begin
				res.status = ST_RANGE;
			end else if (top_of_stack == 0) begin
				res.status = ST_NONE_OUT;
			end else if (!free_list[below_idx].taken) begin
				res.status = ST_INCONSISTENT;
			end else begin
				// a slot that is already free is pushed again, not caught
				top_of_stack--;
				free_list[below_idx].slot  = slot[SLOT_W-1:0];
				free_list[below_idx].taken = 1'b0;
			end
		end
		res.granted = grant_wide[GRANT_W-1:0];
		res.count   = top_of_stack[COUNT_W-1:0];
	endtask

	// Watch both channels; requests are queued before results are compared
	always @(posedge clk or negedge arst_n) begin : watch
		alloc_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < POOL_SIZE; i++) begin
				free_list[i[SLOT_W-1:0]].slot  = i[SLOT_W-1:0];
				free_list[i[SLOT_W-1:0]].taken = 1'b0;
			end
			top_of_stack = 0;
			owed_results.delete();
		end else begin
			if (in_valid && in_ready) begin
				step_free_stack(mode_t'(mode), release_slot, want);
				owed_results.push_back(want);
				if (int'(top_of_stack) > peak_in_use)
					peak_in_use = top_of_stack;
			end
			if (out_valid && out_ready) begin
				if (owed_results.size() == 0) begin
					flag_mismatch("result with no request outstanding", 32'(status), 0);
				end else begin
					want = owed_results.pop_front();
					if (granted_slot !== want.granted)
						flag_mismatch("granted_slot", 32'(granted_slot),
							32'(want.granted));
					if (status !== want.status)
						flag_mismatch("status", 32'(status), 32'(want.status));
					if (in_use_count !== want.count)
						flag_mismatch("in_use_count", 32'(in_use_count),
							32'(want.count));
					if (want.status == ST_EXHAUSTED)
						exhausted_hits++;
					if (want.status == ST_NONE_OUT)
						none_out_hits++;
					checked++;
				end
			end
		end
		pending = owed_results.size();
	end

endmodule

>>> verif/tb_free_index_stack_allocator.sv
// Testbench top for the free index stack allocator: clock, reset, request and
// stall stimulus, verdict. Depends on fisa_pkg, the block and fisa_scoreboard.
module tb_free_index_stack_allocator;
	timeunit 1ns;
	timeprecision 1ps;
	import fisa_pkg::*;

	localparam int POOL        = 64;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 400;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               mode;
	logic [REL_W-1:0]   release_slot;
	logic               out_valid;
	logic               out_ready;
	logic [GRANT_W-1:0] granted_slot;
	status_t            status;
	logic [COUNT_W-1:0] in_use_count;

	int fail_count, pending, checked, peak_in_use, exhausted_hits, none_out_hits;
	int idle_pct, stall_pct;
	int allocs_sent, releases_sent;
	int cycles;

	free_index_stack_allocator #(.POOL_SIZE(POOL)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.release_slot (release_slot),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.granted_slot (granted_slot),
		.status       (status),
		.in_use_count (in_use_count)
	);

	fisa_scoreboard #(.POOL_SIZE(POOL)) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.release_slot   (release_slot),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.granted_slot   (granted_slot),
		.status         (status),
		.in_use_count   (in_use_count),
		.fail_count     (fail_count),
		.pending        (pending),
		.checked        (checked),
		.peak_in_use    (peak_in_use),
		.exhausted_hits (exhausted_hits),
		.none_out_hits  (none_out_hits)
	);

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		mode         = MODE_ALLOC;
		release_slot = '0;
		out_ready    = 1'b0;
		idle_pct     = 0;
		stall_pct    = 0;
		cycles       = 0;
	end

	always #2 clk = ~clk;

	// Receiver stalls at random
	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("free_index_stack_allocator verification failed");
			$finish;
		end
	end

	// Present one request, starting and ending at a falling edge
	task automatic send_request(input mode_t op, input logic [REL_W-1:0] slot);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		mode         <= op;
		release_slot <= slot;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		if (op == MODE_ALLOC)
			allocs_sent++;
		else
			releases_sent++;
	endtask

	// Hold off until every result owed has come back
	task automatic wait_results_in();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
	endtask

	// Random requests in runs that lean toward filling, churning or draining the pool
	task automatic run_phase(input int n_items);
		int alloc_pct, run_left;
		alloc_pct = 50;
		run_left  = 0;
		repeat (n_items) begin
			if (run_left == 0) begin
				run_left = $urandom_range(20, 80);
				case ($urandom_range(0, 2))
					0: alloc_pct = 95;
					1: alloc_pct = 50;
					default: alloc_pct = 5;
				endcase
			end
			run_left--;
			if ($urandom_range(0, 99) < alloc_pct)
				send_request(MODE_ALLOC, REL_W'($urandom_range(0, 255)));
			else if ($urandom_range(0, 99) < 85)
				send_request(MODE_RELEASE, REL_W'($urandom_range(0, POOL - 1)));
			else
				send_request(MODE_RELEASE, REL_W'($urandom_range(POOL, 255)));
		end
	endtask

	initial begin
		allocs_sent   = 0;
		releases_sent = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty pool, range check first, reuse of pushed slots, double release
		send_request(MODE_RELEASE, 8'd0);
		send_request(MODE_RELEASE, 8'd255);
		send_request(MODE_RELEASE, REL_W'(POOL));
		send_request(MODE_ALLOC, 8'd255);
		send_request(MODE_ALLOC, 8'd0);
		send_request(MODE_RELEASE, REL_W'(POOL - 1));
		send_request(MODE_ALLOC, 8'd0);
		send_request(MODE_RELEASE, REL_W'(POOL - 1));
		send_request(MODE_RELEASE, REL_W'(POOL - 1));
		send_request(MODE_RELEASE, 8'd5);
		send_request(MODE_ALLOC, 8'd170);
		send_request(MODE_ALLOC, 8'd85);
		send_request(MODE_RELEASE, 8'd0);
		send_request(MODE_RELEASE, 8'd128);
		send_request(MODE_ALLOC, 8'd0);
		wait_results_in();

		// Random phases: free flow, idle sender, stalling receiver, both
		run_phase(PHASE_ITEMS);
		wait_results_in();
		idle_pct = 63;
		run_phase(PHASE_ITEMS);
		wait_results_in();
		idle_pct  = 0;
		stall_pct = 63;
		run_phase(PHASE_ITEMS);
		wait_results_in();
		idle_pct  = 36;
		stall_pct = 36;
		run_phase(PHASE_ITEMS);
		wait_results_in();
		repeat (8) @(posedge clk);

		$display("Ran %0d allocates, %0d releases over four idle/stall mixes; %0d compared.",
			allocs_sent, releases_sent, checked);
		$display("Peak use %0d of %0d slots; pool dry %0d times, empty releases %0d times.",
			peak_in_use, POOL, exhausted_hits, none_out_hits);
		if (fail_count == 0)
			$display("free_index_stack_allocator verification clean");
		else
			$display("free_index_stack_allocator verification failed");
		$finish;
	end

endmodule
